// File: design/bfac_pkg.sv
package bfac_pkg;

  // Default sizes of the store and of the probe sequence
  localparam int DEF_FILTER_BITS = 65536;
  localparam int DEF_MAX_PROBES  = 16;

  // Store word geometry
  localparam int WORD_BITS  = 64;
  localparam int WORD_SHIFT = 6;

  // Key hashing
  localparam int KEY_W     = 32;
  localparam int KEY_SHIFT = 16;

  // Configuration port
  localparam int SIZE_CFG_W  = 17;
  localparam int COUNT_CFG_W = 5;
  localparam int CFG_DATA_W  = 17;
  localparam int CFG_IDX_W   = 1;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER_SIZE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HASH_COUNT  = 1'd1;

  localparam logic [SIZE_CFG_W-1:0]  RST_FILTER_SIZE = 17'd65536;
  localparam logic [COUNT_CFG_W-1:0] RST_HASH_COUNT  = 5'd4;

  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_CHECK = 1'b1
  } opcode_e;

  // Fold the two key words into one 32-bit base value
  function automatic logic [KEY_W-1:0] base_of(input logic [KEY_W-1:0] lo,
                                               input logic [KEY_W-1:0] hi);
    base_of = lo ^ (hi << KEY_SHIFT);
  endfunction

endpackage

// File: design/bfac_in_if.sv
interface bfac_in_if;
  logic                        valid;
  logic                        ready;
  bfac_pkg::opcode_e           opcode;
  logic [bfac_pkg::KEY_W-1:0]  key_low;
  logic [bfac_pkg::KEY_W-1:0]  key_high;

  modport source (output valid, output opcode, output key_low, output key_high,
                  input ready);
  modport sink   (input valid, input opcode, input key_low, input key_high,
                  output ready);
endinterface

// File: design/bfac_out_if.sv
interface bfac_out_if;
  logic valid;
  logic ready;
  logic maybe_present;

  modport source (output valid, output maybe_present, input ready);
  modport sink   (input valid, input maybe_present, output ready);
endinterface

// File: design/bfac_mod.sv
module bfac_mod #(
  parameter int SW = 17
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [bfac_pkg::KEY_W-1:0]  dividend_i,
  input  logic [SW-1:0]               divisor_i,
  output logic                        done_o,
  output logic [SW-1:0]               rem_o
);

  localparam int CW = $clog2(bfac_pkg::KEY_W);

  logic                        busy_q;
  logic                        done_q;
  logic [CW-1:0]               cnt_q;
  logic [bfac_pkg::KEY_W-1:0]  quo_q;
  logic [SW-1:0]               rem_q;
  logic [SW:0]                 trial;
  logic [SW:0]                 diff;

  // Shift in the next dividend bit and subtract the divisor if it fits
  assign trial = {rem_q, quo_q[bfac_pkg::KEY_W-1]};
  assign diff  = trial - {1'b0, divisor_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CW'(bfac_pkg::KEY_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder datapath, one quotient bit a cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
    end else if (busy_q) begin
      quo_q <= quo_q << 1;
      rem_q <= (trial >= {1'b0, divisor_i}) ? diff[SW-1:0] : trial[SW-1:0];
    end
  end

  assign done_o = done_q;
  assign rem_o  = rem_q;

  a_rem_below_divisor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (rem_q < divisor_i))
    else $error("remainder not below divisor");

endmodule

// File: design/bfac_store.sv
module bfac_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                            clk_i,
  input  logic                            we_i,
  input  logic [AW-1:0]                   waddr_i,
  input  logic [bfac_pkg::WORD_BITS-1:0]  wdata_i,
  input  logic                            re_i,
  input  logic [AW-1:0]                   raddr_i,
  output logic [bfac_pkg::WORD_BITS-1:0]  rdata_o
);

  logic [bfac_pkg::WORD_BITS-1:0] mem [DEPTH];
  logic [bfac_pkg::WORD_BITS-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: design/bfac_probe.sv
module bfac_probe #(
  parameter int FILTER_BITS = bfac_pkg::DEF_FILTER_BITS,
  parameter int MAX_PROBES  = bfac_pkg::DEF_MAX_PROBES
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic [$clog2(FILTER_BITS+1)-1:0]       size_i,
  input  logic [$clog2(MAX_PROBES+1)-1:0]        probes_i,
  bfac_in_if.sink                                in_s,
  bfac_out_if.source                             out_s
);

  localparam int SW          = $clog2(FILTER_BITS + 1);
  localparam int PCW         = $clog2(MAX_PROBES + 1);
  localparam int WB          = bfac_pkg::WORD_BITS;
  localparam int BW          = bfac_pkg::WORD_SHIFT;
  localparam int STORE_WORDS = (FILTER_BITS + WB - 1) / WB;
  localparam int AW          = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_PROBE,
    ST_DRAIN,
    ST_DONE
  } state_e;

  state_e              state_q, state_d;
  logic [AW-1:0]       clr_addr_q, clr_addr_d;
  logic                out_valid_q, out_valid_d;
  logic                present_q, present_d;
  logic                s2_valid_q, s2_valid_d;
  logic                fwd_valid_q, fwd_valid_d;
  bfac_pkg::opcode_e   op_q, op_d;
  logic                all_set_q, all_set_d;
  logic [SW-1:0]       r_q, r_d;
  logic [SW-1:0]       pos_q, pos_d;
  logic [PCW-1:0]      left_q, left_d;
  logic [AW-1:0]       s2_addr_q, s2_addr_d;
  logic [BW-1:0]       s2_bit_q, s2_bit_d;
  logic [AW-1:0]       fwd_addr_q, fwd_addr_d;
  logic [WB-1:0]       fwd_data_q, fwd_data_d;

  logic                mod_start;
  logic                mod_done;
  logic [SW-1:0]       mod_rem;
  logic                rd_en;
  logic [WB-1:0]       rd_data;
  logic [WB-1:0]       cur_word;
  logic [WB-1:0]       set_word;
  logic                is_add;
  logic                clearing;
  logic [SW-1:0]       pos_word;
  logic [AW-1:0]       pos_addr;
  logic [SW:0]         pos_sum;
  logic [SW:0]         pos_wrap;
  logic [SW-1:0]       next_pos;
  logic                st_we;
  logic [AW-1:0]       st_waddr;
  logic [WB-1:0]       st_wdata;

  // Base modulo size gives the first position and the stride
  bfac_mod #(
    .SW (SW)
  ) u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (mod_start),
    .dividend_i (bfac_pkg::base_of(in_s.key_low, in_s.key_high)),
    .divisor_i  (size_i),
    .done_o     (mod_done),
    .rem_o      (mod_rem)
  );

  bfac_store #(
    .DEPTH (STORE_WORDS),
    .AW    (AW)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .re_i    (rd_en),
    .raddr_i (pos_addr),
    .rdata_o (rd_data)
  );

  // Word address of the current probe position
  assign pos_word = pos_q >> BW;
  assign pos_addr = pos_word[AW-1:0];

  // Advance the position by the stride, wrapping once at the size
  assign pos_sum  = {1'b0, pos_q} + {1'b0, r_q};
  assign pos_wrap = pos_sum - {1'b0, size_i};
  assign next_pos = (pos_sum >= {1'b0, size_i}) ? pos_wrap[SW-1:0] : pos_sum[SW-1:0];

  // Take the word just written when the read came back stale
  assign cur_word = (fwd_valid_q && (fwd_addr_q == s2_addr_q)) ? fwd_data_q : rd_data;
  assign set_word = cur_word | (WB'(1) << s2_bit_q);
  assign is_add   = (op_q == bfac_pkg::OP_ADD);
  assign clearing = (state_q == ST_CLEAR);

  // Store write: zero sweep after reset, else read-modify-write of an add
  assign st_we    = clearing || (s2_valid_q && is_add);
  assign st_waddr = clearing ? clr_addr_q : s2_addr_q;
  assign st_wdata = clearing ? '0 : set_word;

  always_comb begin
    state_d     = state_q;
    clr_addr_d  = clr_addr_q;
    out_valid_d = out_valid_q && !out_s.ready;
    present_d   = present_q;
    s2_valid_d  = 1'b0;
    fwd_valid_d = s2_valid_q && is_add;
    fwd_addr_d  = s2_addr_q;
    fwd_data_d  = set_word;
    op_d        = op_q;
    all_set_d   = all_set_q;
    r_d         = r_q;
    pos_d       = pos_q;
    left_d      = left_q;
    s2_addr_d   = s2_addr_q;
    s2_bit_d    = s2_bit_q;
    mod_start   = 1'b0;
    rd_en       = 1'b0;

    // Second probe stage: test the bit for a check
    if (s2_valid_q && !is_add && !cur_word[s2_bit_q]) begin
      all_set_d = 1'b0;
    end

    case (state_q)
      ST_CLEAR: begin
        clr_addr_d = clr_addr_q + 1'b1;
        if (clr_addr_q == AW'(STORE_WORDS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_s.valid) begin
          op_d      = in_s.opcode;
          all_set_d = 1'b1;
          mod_start = 1'b1;
          state_d   = ST_MOD;
        end
      end
      ST_MOD: begin
        if (mod_done) begin
          r_d    = mod_rem;
          pos_d  = mod_rem;
          left_d = probes_i;
          state_d = (probes_i == '0) ? ST_DONE : ST_PROBE;
        end
      end
      ST_PROBE: begin
        rd_en      = 1'b1;
        s2_valid_d = 1'b1;
        s2_addr_d  = pos_addr;
        s2_bit_d   = pos_q[BW-1:0];
        pos_d      = next_pos;
        left_d     = left_q - 1'b1;
        if (left_q == PCW'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (is_add) begin
          state_d = ST_IDLE;
        end else if (!out_valid_q || out_s.ready) begin
          out_valid_d = 1'b1;
          present_d   = all_set_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state and the output word flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_addr_q  <= '0;
      out_valid_q <= 1'b0;
      s2_valid_q  <= 1'b0;
      fwd_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_addr_q  <= clr_addr_d;
      out_valid_q <= out_valid_d;
      s2_valid_q  <= s2_valid_d;
      fwd_valid_q <= fwd_valid_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    present_q  <= present_d;
    fwd_addr_q <= fwd_addr_d;
    fwd_data_q <= fwd_data_d;
    op_q       <= op_d;
    all_set_q  <= all_set_d;
    r_q        <= r_d;
    pos_q      <= pos_d;
    left_q     <= left_d;
    s2_addr_q  <= s2_addr_d;
    s2_bit_q   <= s2_bit_d;
  end

  assign in_s.ready          = (state_q == ST_IDLE);
  assign out_s.valid         = out_valid_q;
  assign out_s.maybe_present = present_q;

  a_stage2_in_probe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s2_valid_q |-> (state_q == ST_PROBE || state_q == ST_DRAIN))
    else $error("probe read pending outside probe phase");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PROBE) |-> (pos_q < size_i))
    else $error("probe position beyond filter size");

  a_result_only_check: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(op_q == bfac_pkg::OP_CHECK && state_q == ST_DONE))
    else $error("result word raised without a finished check");

endmodule

// File: design/bloom_filter_add_check.sv
// Bloom filter with add and check words.
// in_i carries an opcode (add or check) and two 32-bit key words; out_o
// carries one maybe_present word for each check, none for an add.
// The configuration port writes filter_size (index 0) and hash_count
// (index 1) through cfg_we_i, cfg_idx_i and cfg_data_i, taken on the
// clock edge where cfg_we_i is high.
// An item first takes the bit-serial remainder of the hashed key by
// filter_size; then the store (64-bit words, one read and one write
// port) is read one probe a cycle, and adds write back through the same
// memory with one-deep forwarding. One item is in work at a time.
// After its last probe, a check result passes the drain and done states
// before it is registered in the output.
// After reset the store is swept to zero, one word a cycle, through all
// its words (1024 by default); in_i stays not ready meanwhile.
// A finished result waits in the output register while the receiver
// stalls; the next item is still taken and runs up to its own result.
module bloom_filter_add_check #(
  parameter int FILTER_BITS = bfac_pkg::DEF_FILTER_BITS,
  parameter int MAX_PROBES  = bfac_pkg::DEF_MAX_PROBES
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bfac_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [bfac_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  bfac_in_if.sink                             in_i,
  bfac_out_if.source                          out_o
);

  localparam int SW  = $clog2(FILTER_BITS + 1);
  localparam int PCW = $clog2(MAX_PROBES + 1);

  logic [bfac_pkg::SIZE_CFG_W-1:0]  size_q;
  logic [bfac_pkg::COUNT_CFG_W-1:0] count_q;
  logic [31:0]                      size_ext;
  logic [SW-1:0]                    size_used;
  logic [7:0]                       count_ext;
  logic [7:0]                       max_ext;
  logic [PCW-1:0]                   probes_used;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q  <= bfac_pkg::RST_FILTER_SIZE;
      count_q <= bfac_pkg::RST_HASH_COUNT;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bfac_pkg::REG_FILTER_SIZE: size_q  <= cfg_data_i[bfac_pkg::SIZE_CFG_W-1:0];
        bfac_pkg::REG_HASH_COUNT:  count_q <= cfg_data_i[bfac_pkg::COUNT_CFG_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Clamp the size to 1..FILTER_BITS
  always_comb begin
    size_ext = 32'(size_q);
    if (size_q == '0) begin
      size_used = SW'(1);
    end else if (size_ext > 32'(FILTER_BITS)) begin
      size_used = SW'(FILTER_BITS);
    end else begin
      size_used = size_ext[SW-1:0];
    end
  end

  // Clamp the probe count to MAX_PROBES
  assign count_ext   = 8'(count_q);
  assign max_ext     = 8'(MAX_PROBES);
  assign probes_used = (count_ext > max_ext) ? PCW'(MAX_PROBES) : count_ext[PCW-1:0];

  bfac_probe #(
    .FILTER_BITS (FILTER_BITS),
    .MAX_PROBES  (MAX_PROBES)
  ) u_probe (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .size_i   (size_used),
    .probes_i (probes_used),
    .in_s     (in_i),
    .out_s    (out_o)
  );

endmodule
